[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the anchor pixel selector.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define APS_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle implication failed");
`define APS_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle implication failed");
`else
`define APS_ASSERT_IMP(label, clk, rst, a, b)
`define APS_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

[rtl/apsel_pkg.sv]
// Types, constants and codes of the anchor pixel selector.
// Used by the configuration interface, the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package apsel_pkg;

  localparam int MAX_PIXELS = 65536;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int MAX_WIDTH  = 4096;
  localparam int WIDTH_W    = 13;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [15:0] NDVI_MIN_RAW = 16'sd3276;

  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NDVI_LOW    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NDVI_HIGH   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALBEDO_LOW  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALBEDO_HIGH = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW    = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH   = 8'd7;

  typedef enum logic [2:0] {
    SCAN_QUANT,
    SCAN_COUNT,
    SCAN_MED,
    SCAN_LESS,
    SCAN_PICK
  } scan_kind_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_QSETUP,
    S_QSTART,
    S_QWAIT,
    S_QBIT,
    S_QSTORE,
    S_CSTART,
    S_CWAIT,
    S_CTHR,
    S_MSTART,
    S_MWAIT,
    S_MBIT,
    S_LSTART,
    S_LWAIT,
    S_RANK,
    S_PSTART,
    S_PWAIT,
    S_DSTART,
    S_DSTEP,
    S_OUT,
    S_EMPTY
  } state_t;

  typedef struct packed {
    logic       load_en;
    logic       scan_start;
    scan_kind_t scan_kind;
    logic [2:0] qsel;
    logic [3:0] bit_idx;
    logic       load_thr_quant;
    logic       load_thr_med;
    logic       res_clear;
    logic       bit_update;
    logic       store_bound;
    logic       load_rank;
    logic       div_start;
    logic       div_step;
    logic       out_load;
    logic       out_found;
    logic       image_done;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic vc_zero;
    logic cnt_zero;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

[rtl/apsel_pix_if.sv]
// Pixel input channel of the anchor pixel selector.
// Does not depend on apsel_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface apsel_pix_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] ndvi;
  logic               ndvi_ok;
  logic        [15:0] albedo;
  logic               albedo_ok;
  logic        [15:0] temperature;
  logic               temp_ok;
  logic signed [19:0] net_radiation;
  logic signed [19:0] soil_heat;
  logic               last;

  modport source (output valid, ndvi, ndvi_ok, albedo, albedo_ok, temperature, temp_ok,
                  net_radiation, soil_heat, last, input ready);
  modport sink (input valid, ndvi, ndvi_ok, albedo, albedo_ok, temperature, temp_ok,
                net_radiation, soil_heat, last, output ready);
endinterface
`default_nettype wire

[rtl/apsel_cfg_if.sv]
// Configuration write channel of the anchor pixel selector.
// Widths come from apsel_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface apsel_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [apsel_pkg::CFG_IDX_W-1:0]  index;
  logic [apsel_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/apsel_res_if.sv]
// Result output channel of the anchor pixel selector.
// Carries one result per image: the selected anchor pixel, or found low when none passes.
`timescale 1ns / 1ps
`default_nettype none
interface apsel_res_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [15:0] pick_ndvi;
  logic        [15:0] pick_temperature;
  logic signed [19:0] pick_net_radiation;
  logic signed [19:0] pick_soil_heat;
  logic signed [20:0] pick_heat_term;
  logic        [15:0] pick_row;
  logic        [11:0] pick_col;

  modport source (output valid, found, pick_ndvi, pick_temperature, pick_net_radiation,
                  pick_soil_heat, pick_heat_term, pick_row, pick_col, input ready);
  modport sink (input valid, found, pick_ndvi, pick_temperature, pick_net_radiation,
                pick_soil_heat, pick_heat_term, pick_row, pick_col, output ready);
endinterface
`default_nettype wire

[rtl/apsel_ctrl.sv]
// Sequencer of the anchor pixel selector: loading, quantile searches,
// candidate median search, pick and divide. Uses apsel_pkg types.
`timescale 1ns / 1ps
`default_nettype none
module apsel_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_last,
  input  wire apsel_pkg::status_t status,
  output apsel_pkg::cmd_t         cmd
);

  apsel_pkg::state_t state, state_next;
  logic [2:0] qi, qi_next;
  logic [3:0] bit_idx, bit_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= apsel_pkg::S_LOAD;
      qi      <= 3'd0;
      bit_idx <= 4'd15;
    end else begin
      state   <= state_next;
      qi      <= qi_next;
      bit_idx <= bit_idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    qi_next      = qi;
    bit_idx_next = bit_idx;
    case (state)
      apsel_pkg::S_LOAD: begin
        if (in_valid && in_last) begin
          state_next = apsel_pkg::S_QSETUP;
          qi_next    = 3'd0;
        end
      end
      apsel_pkg::S_QSETUP: begin
        bit_idx_next = 4'd15;
        state_next   = status.vc_zero ? apsel_pkg::S_QSTORE : apsel_pkg::S_QSTART;
      end
      apsel_pkg::S_QSTART: state_next = apsel_pkg::S_QWAIT;
      apsel_pkg::S_QWAIT: begin
        if (status.scan_done) state_next = apsel_pkg::S_QBIT;
      end
      apsel_pkg::S_QBIT: begin
        if (bit_idx == 4'd0) begin
          state_next = apsel_pkg::S_QSTORE;
        end else begin
          bit_idx_next = bit_idx - 4'd1;
          state_next   = apsel_pkg::S_QSTART;
        end
      end
      apsel_pkg::S_QSTORE: begin
        if (qi == 3'd5) begin
          state_next = apsel_pkg::S_CSTART;
        end else begin
          qi_next    = qi + 3'd1;
          state_next = apsel_pkg::S_QSETUP;
        end
      end
      apsel_pkg::S_CSTART: state_next = apsel_pkg::S_CWAIT;
      apsel_pkg::S_CWAIT: begin
        if (status.scan_done) state_next = apsel_pkg::S_CTHR;
      end
      apsel_pkg::S_CTHR: begin
        bit_idx_next = 4'd15;
        state_next   = status.cnt_zero ? apsel_pkg::S_EMPTY : apsel_pkg::S_MSTART;
      end
      apsel_pkg::S_MSTART: state_next = apsel_pkg::S_MWAIT;
      apsel_pkg::S_MWAIT: begin
        if (status.scan_done) state_next = apsel_pkg::S_MBIT;
      end
      apsel_pkg::S_MBIT: begin
        if (bit_idx == 4'd0) begin
          state_next = apsel_pkg::S_LSTART;
        end else begin
          bit_idx_next = bit_idx - 4'd1;
          state_next   = apsel_pkg::S_MSTART;
        end
      end
      apsel_pkg::S_LSTART: state_next = apsel_pkg::S_LWAIT;
      apsel_pkg::S_LWAIT: begin
        if (status.scan_done) state_next = apsel_pkg::S_RANK;
      end
      apsel_pkg::S_RANK: state_next = apsel_pkg::S_PSTART;
      apsel_pkg::S_PSTART: state_next = apsel_pkg::S_PWAIT;
      apsel_pkg::S_PWAIT: begin
        if (status.scan_done) state_next = apsel_pkg::S_DSTART;
      end
      apsel_pkg::S_DSTART: begin
        bit_idx_next = 4'd15;
        state_next   = apsel_pkg::S_DSTEP;
      end
      apsel_pkg::S_DSTEP: begin
        if (bit_idx == 4'd0) begin
          state_next = apsel_pkg::S_OUT;
        end else begin
          bit_idx_next = bit_idx - 4'd1;
        end
      end
      apsel_pkg::S_OUT, apsel_pkg::S_EMPTY: begin
        if (!status.out_busy) state_next = apsel_pkg::S_LOAD;
      end
      default: state_next = apsel_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.qsel    = qi;
    cmd.bit_idx = bit_idx;
    cmd.scan_kind = apsel_pkg::SCAN_QUANT;
    case (state)
      apsel_pkg::S_LOAD: cmd.load_en = 1'b1;
      apsel_pkg::S_QSETUP: begin
        cmd.load_thr_quant = 1'b1;
        cmd.res_clear      = 1'b1;
      end
      apsel_pkg::S_QSTART: begin
        cmd.scan_start = 1'b1;
        cmd.scan_kind  = apsel_pkg::SCAN_QUANT;
      end
      apsel_pkg::S_QBIT: cmd.bit_update = 1'b1;
      apsel_pkg::S_QSTORE: cmd.store_bound = 1'b1;
      apsel_pkg::S_CSTART: begin
        cmd.scan_start = 1'b1;
        cmd.scan_kind  = apsel_pkg::SCAN_COUNT;
      end
      apsel_pkg::S_CTHR: begin
        cmd.load_thr_med = 1'b1;
        cmd.res_clear    = 1'b1;
      end
      apsel_pkg::S_MSTART: begin
        cmd.scan_start = 1'b1;
        cmd.scan_kind  = apsel_pkg::SCAN_MED;
      end
      apsel_pkg::S_MBIT: cmd.bit_update = 1'b1;
      apsel_pkg::S_LSTART: begin
        cmd.scan_start = 1'b1;
        cmd.scan_kind  = apsel_pkg::SCAN_LESS;
      end
      apsel_pkg::S_RANK: cmd.load_rank = 1'b1;
      apsel_pkg::S_PSTART: begin
        cmd.scan_start = 1'b1;
        cmd.scan_kind  = apsel_pkg::SCAN_PICK;
      end
      apsel_pkg::S_DSTART: cmd.div_start = 1'b1;
      apsel_pkg::S_DSTEP: cmd.div_step = 1'b1;
      apsel_pkg::S_OUT: begin
        cmd.out_load   = !status.out_busy;
        cmd.out_found  = 1'b1;
        cmd.image_done = !status.out_busy;
      end
      apsel_pkg::S_EMPTY: begin
        cmd.out_load   = !status.out_busy;
        cmd.out_found  = 1'b0;
        cmd.image_done = !status.out_busy;
      end
      default: cmd.load_en = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/apsel_dp.sv]
// Datapath of the anchor pixel selector: pixel stores, scan unit, counters,
// bit-by-bit searches, divider, configuration and result registers.
`timescale 1ns / 1ps
`default_nettype none
module apsel_dp (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire apsel_pkg::cmd_t cmd,
  output apsel_pkg::status_t status,
  apsel_pix_if.sink        pix,
  apsel_cfg_if.sink        cfg,
  apsel_res_if.source      res
);

  localparam int AW = apsel_pkg::ADDR_W;
  localparam int CW = apsel_pkg::CNT_W;

  logic [50:0] band_mem [apsel_pkg::MAX_PIXELS];
  logic [39:0] flux_mem [apsel_pkg::MAX_PIXELS];

  logic        mode;
  logic [12:0] image_width;
  logic [15:0] frac [6];

  logic [CW-1:0] pixel_count;
  logic [CW-1:0] vc_n, vc_a, vc_t;
  logic [15:0]   bounds [6];

  logic          wr_en;
  logic          scan_act, issue, rd_v;
  logic [CW-1:0] scan_addr;
  logic [AW-1:0] rd_idx;
  apsel_pkg::scan_kind_t kind;
  logic [50:0]   band_q;
  logic [39:0]   flux_q;

  logic [CW-1:0] cnt, thr;
  logic [15:0]   sres;
  logic          picked;
  logic [AW-1:0] pick_idx;
  logic [50:0]   pick_band;
  logic [39:0]   pick_flux;

  logic [15:0]   quo;
  logic [12:0]   rem;
  logic [12:0]   wc;
  logic [13:0]   div_sh;

  logic [15:0]   nd, al, tp, key, low_mask, trial;
  logic [2:0]    oks;
  logic          key_ok, av, nv, tv, pass, hit;
  logic [CW-1:0] vc_sel;
  logic [15:0]   frac_sel;
  logic [32:0]   prod;
  logic signed [20:0] heat;

  assign wr_en = cmd.load_en && pix.valid && !pixel_count[AW];
  assign pix.ready = cmd.load_en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= 1'b0;
      image_width <= 13'd4096;
      frac[0]     <= 16'd9830;
      frac[1]     <= 16'd63569;
      frac[2]     <= 16'd32768;
      frac[3]     <= 16'd49152;
      frac[4]     <= 16'd55705;
      frac[5]     <= 16'd63569;
    end else if (cfg.valid) begin
      case (cfg.index)
        apsel_pkg::REG_MODE:        mode        <= cfg.data[0];
        apsel_pkg::REG_WIDTH:       image_width <= cfg.data[12:0];
        apsel_pkg::REG_NDVI_LOW:    frac[0]     <= cfg.data;
        apsel_pkg::REG_NDVI_HIGH:   frac[1]     <= cfg.data;
        apsel_pkg::REG_ALBEDO_LOW:  frac[2]     <= cfg.data;
        apsel_pkg::REG_ALBEDO_HIGH: frac[3]     <= cfg.data;
        apsel_pkg::REG_TEMP_LOW:    frac[4]     <= cfg.data;
        apsel_pkg::REG_TEMP_HIGH:   frac[5]     <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      band_mem[pixel_count[AW-1:0]] <= {pix.temp_ok, pix.albedo_ok, pix.ndvi_ok,
                                        pix.temperature, pix.albedo, pix.ndvi};
    end
    if (issue) begin
      band_q <= band_mem[scan_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      flux_mem[pixel_count[AW-1:0]] <= {pix.soil_heat, pix.net_radiation};
    end
    if (issue) begin
      flux_q <= flux_mem[scan_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.image_done) begin
      pixel_count <= '0;
      vc_n        <= '0;
      vc_a        <= '0;
      vc_t        <= '0;
    end else if (wr_en) begin
      pixel_count <= pixel_count + CW'(1);
      vc_n        <= vc_n + CW'(pix.ndvi_ok);
      vc_a        <= vc_a + CW'(pix.albedo_ok);
      vc_t        <= vc_t + CW'(pix.temp_ok);
    end
  end

  assign issue = scan_act && (scan_addr < pixel_count);
  assign status.scan_done = scan_act && !issue && !rd_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_act <= 1'b0;
      rd_v     <= 1'b0;
    end else begin
      rd_v <= issue;
      if (cmd.scan_start) begin
        scan_act <= 1'b1;
      end else if (status.scan_done) begin
        scan_act <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr <= '0;
      kind      <= cmd.scan_kind;
    end else if (issue) begin
      scan_addr <= scan_addr + CW'(1);
    end
    if (issue) begin
      rd_idx <= scan_addr[AW-1:0];
    end
  end

  assign nd  = band_q[15:0];
  assign al  = band_q[31:16];
  assign tp  = band_q[47:32];
  assign oks = band_q[50:48];

  assign low_mask = (16'd1 << cmd.bit_idx) - 16'd1;
  assign trial    = sres | low_mask;

  always_comb begin
    case (cmd.qsel[2:1])
      2'd0: begin
        key    = nd ^ 16'h8000;
        key_ok = oks[0];
        vc_sel = vc_n;
      end
      2'd1: begin
        key    = al;
        key_ok = oks[1];
        vc_sel = vc_a;
      end
      default: begin
        key    = tp;
        key_ok = oks[2];
        vc_sel = vc_t;
      end
    endcase
  end

  always_comb begin
    av = oks[1] && (al > bounds[2]) && (al < bounds[3]);
    if (mode) begin
      nv = oks[0] && ($signed(nd) > $signed(bounds[1]));
      tv = oks[2] && (tp < bounds[4]);
    end else begin
      nv = oks[0] && ($signed(nd) > apsel_pkg::NDVI_MIN_RAW) &&
           ($signed(nd) < $signed(bounds[0]));
      tv = oks[2] && (tp > bounds[4]) && (tp < bounds[5]);
    end
    pass = nv && av && tv;
  end

  always_comb begin
    case (kind)
      apsel_pkg::SCAN_QUANT: hit = key_ok && (key <= trial);
      apsel_pkg::SCAN_COUNT: hit = pass;
      apsel_pkg::SCAN_MED:   hit = pass && (tp <= trial);
      apsel_pkg::SCAN_LESS:  hit = pass && (tp < sres);
      apsel_pkg::SCAN_PICK:  hit = pass && (tp == sres);
      default:               hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      cnt    <= '0;
      picked <= 1'b0;
    end else if (rd_v && hit) begin
      cnt <= cnt + CW'(1);
      if ((kind == apsel_pkg::SCAN_PICK) && (cnt == thr) && !picked) begin
        picked    <= 1'b1;
        pick_idx  <= rd_idx;
        pick_band <= band_q;
        pick_flux <= flux_q;
      end
    end
  end

  assign frac_sel = frac[cmd.qsel];
  assign prod     = {17'd0, frac_sel} * {16'd0, vc_sel};

  always_ff @(posedge clk) begin
    if (cmd.load_thr_quant) begin
      thr <= prod[32:16];
    end else if (cmd.load_thr_med) begin
      thr <= {1'b0, cnt[CW-1:1]};
    end else if (cmd.load_rank) begin
      thr <= thr - cnt;
    end
    if (cmd.res_clear) begin
      sres <= '0;
    end else if (cmd.bit_update && !(cnt > thr)) begin
      sres <= sres | (16'd1 << cmd.bit_idx);
    end
  end

  assign status.vc_zero  = (vc_sel == '0);
  assign status.cnt_zero = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) bounds[i] <= '0;
    end else if (cmd.store_bound) begin
      if (status.vc_zero) begin
        bounds[cmd.qsel] <= '0;
      end else if (cmd.qsel[2:1] == 2'd0) begin
        bounds[cmd.qsel] <= sres ^ 16'h8000;
      end else begin
        bounds[cmd.qsel] <= sres;
      end
    end
  end

  always_comb begin
    if (image_width == 13'd0) begin
      wc = 13'd1;
    end else if (image_width > 13'(apsel_pkg::MAX_WIDTH)) begin
      wc = 13'(apsel_pkg::MAX_WIDTH);
    end else begin
      wc = image_width;
    end
  end

  assign div_sh = {rem, quo[15]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= pick_idx;
      rem <= '0;
    end else if (cmd.div_step) begin
      if (div_sh >= {1'b0, wc}) begin
        rem <= 13'(div_sh - {1'b0, wc});
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= div_sh[12:0];
        quo <= {quo[14:0], 1'b0};
      end
    end
  end

  assign heat = $signed({pick_flux[19], pick_flux[19:0]}) -
                $signed({pick_flux[39], pick_flux[39:20]});

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (cmd.out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_found) begin
        res.found              <= 1'b1;
        res.pick_ndvi          <= $signed(pick_band[15:0]);
        res.pick_temperature   <= pick_band[47:32];
        res.pick_net_radiation <= $signed(pick_flux[19:0]);
        res.pick_soil_heat     <= $signed(pick_flux[39:20]);
        res.pick_heat_term     <= heat;
        res.pick_row           <= quo;
        res.pick_col           <= rem[11:0];
      end else begin
        res.found              <= 1'b0;
        res.pick_ndvi          <= '0;
        res.pick_temperature   <= '0;
        res.pick_net_radiation <= '0;
        res.pick_soil_heat     <= '0;
        res.pick_heat_term     <= '0;
        res.pick_row           <= '0;
        res.pick_col           <= '0;
      end
    end
  end

  assign status.out_busy = res.valid;

endmodule
`default_nettype wire

[rtl/anchor_pixel_select_core.sv]
// Top level of the anchor pixel selector: controller plus datapath.
// Depends on apsel_pkg, the three channel interfaces and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Pixels of one image are taken one per cycle in row-major order and stored
// (up to 65536; later pixels are dropped). After the pixel marked last the
// block stops taking pixels and works on one read port of the pixel store:
// six 16-step quantile searches, a candidate count, a 16-step temperature
// median search, a count of colder candidates and a pick pass, each a full
// scan of N stored pixels, then a bit-serial row/column divide before the
// result is offered. A band with no finite values skips its quantile
// search; when no pixel passes the window tests the later scans and the
// divide are skipped.
// Configuration is taken at any time and is meant to change only when idle.
module anchor_pixel_select_core (
  input wire logic    clk,
  input wire logic    rst,
  apsel_pix_if.sink   pix,
  apsel_cfg_if.sink   cfg,
  apsel_res_if.source res
);

  apsel_pkg::cmd_t    cmd;
  apsel_pkg::status_t status;

  apsel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix.valid),
    .in_last  (pix.last),
    .status   (status),
    .cmd      (cmd)
  );

  apsel_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .pix    (pix),
    .cfg    (cfg),
    .res    (res)
  );

  `APS_ASSERT_NXT(a_stop_after_last, clk, rst, pix.valid && pix.ready && pix.last, !pix.ready)
  `APS_ASSERT_IMP(a_empty_is_zero, clk, rst, res.valid && !res.found, res.pick_row == 16'd0 && res.pick_col == 12'd0 && res.pick_heat_term == 21'sd0)
  `APS_ASSERT_IMP(a_result_after_select, clk, rst, $rose(res.valid), $past(!pix.ready))

endmodule
`default_nettype wire
